[sv/drfe_pkg.sv]
package drfe_pkg;

    // Input sample width and the widest decimal form a 31-bit magnitude needs
    localparam int MAG_W          = 32;
    localparam int MAX_BCD_DIGITS = 10;
    localparam int ND_W           = 4;
    localparam int POS_W          = 5;

    typedef logic signed [MAG_W-1:0] t_value;
    typedef logic [7:0]              t_byte;

    // Status handed from the converter to the frame sequencer
    typedef struct packed {
        logic            done;
        logic            neg;
        logic [ND_W-1:0] nd;
    } t_conv_stat;

    // CRC-16 (reflected) parameters
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Frame characters
    localparam t_byte CH_ZERO  = 8'h30;
    localparam t_byte CH_B     = 8'h42;
    localparam t_byte CH_POS   = 8'h31;
    localparam t_byte CH_NEG   = 8'h32;
    localparam t_byte CH_HEX_A = 8'h60;
    localparam t_byte CH_CR    = 8'h0d;
    localparam t_byte CH_LF    = 8'h0a;

    // Decimal digits held in the BCD register for a given digit limit
    function automatic int bcd_digits(int max_digits);
        return (max_digits < MAX_BCD_DIGITS) ? max_digits : MAX_BCD_DIGITS;
    endfunction

    // Power of ten, evaluated at elaboration only
    function automatic logic [63:0] pow10(int n);
        logic [63:0] r;
        r = 64'd1;
        for (int k = 0; k < n; k++) begin
            r = r * 64'd10;
        end
        return r;
    endfunction

    // Fold one byte into the CRC, one bit per step
    function automatic logic [15:0] crc_byte(logic [15:0] crc, t_byte b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Lowercase hex character for one nibble
    function automatic t_byte hex_char(logic [3:0] nib);
        t_byte r;
        if (nib > 4'd9) begin
            r = CH_HEX_A + {4'h0, nib} - 8'd9;
        end else begin
            r = CH_ZERO + {4'h0, nib};
        end
        return r;
    endfunction

endpackage

[sv/drfe_if.sv]
interface drfe_in_if;
    import drfe_pkg::*;

    logic   valid;
    logic   ready;
    t_value value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface drfe_out_if;
    import drfe_pkg::*;

    logic  valid;
    logic  ready;
    t_byte frame_byte;
    logic  last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

[sv/decimal_reply_frame_encoder_unit.sv]
// Decimal reply frame encoder.
// Input channel i_in carries one signed 32-bit value per transaction; output
// channel o_out carries the reply frame one ASCII byte per transaction, with
// last_byte high on the closing line feed. A frame is 13 + D bytes, D being
// the number of decimal digits of the magnitude (no digits for zero).
// After a transaction on i_in the converter forms and clamps the magnitude,
// runs a shift-and-add-three loop over all 32 input bits (one input bit per
// cycle) and then drops leading zero digits from its BCD register, which is
// MAX_DIGITS digits deep (at most 10). The sequencer then captures the digits
// and the first byte enters the output register; the bytes follow one per
// cycle while o_out.ready holds. A new value is taken only once the line
// feed sits in the output register.
// A stall on o_out freezes the byte sequencer; the CRC advances only as the
// sign and digit bytes enter the output register, so nothing is lost.
// Synchronous reset empties the output register and returns to idle.
module decimal_reply_frame_encoder_unit #(
    parameter int MAX_DIGITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    drfe_in_if.sink     i_in,
    drfe_out_if.source  o_out
);
    import drfe_pkg::*;

    localparam int BCD_DIGITS = bcd_digits(MAX_DIGITS);
    localparam int BCD_W      = 4 * BCD_DIGITS;

    localparam logic [POS_W-1:0] POS_CNT_HI = POS_W'(4);
    localparam logic [POS_W-1:0] POS_CNT_LO = POS_W'(5);
    localparam logic [POS_W-1:0] POS_SIGN   = POS_W'(6);
    localparam logic [POS_W-1:0] POS_DIGIT  = POS_W'(7);
    localparam logic [POS_W-1:0] POS_MAX    = POS_W'(12 + BCD_DIGITS);
    localparam logic [2:0]       OFF_CR     = 3'd4;
    localparam logic [2:0]       OFF_LF     = 3'd5;

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_WAIT = 3'b010,
        T_EMIT = 3'b100
    } t_tstate;

    t_tstate          r_state;
    t_conv_stat       w_stat;
    logic [BCD_W-1:0] w_bcd;
    logic [BCD_W-1:0] r_bcd;
    logic [ND_W-1:0]  r_nd;
    logic             r_neg;
    logic [POS_W-1:0] r_pos;
    logic [15:0]      r_crc;
    logic             r_out_valid;
    t_byte            r_out_byte;
    logic             r_out_last;

    logic             w_accept;
    logic             w_load;
    logic [POS_W-1:0] w_dig_end;
    logic [2:0]       w_off;
    logic [ND_W-1:0]  w_count;
    t_byte            n_byte;
    logic             n_last;
    logic             n_crc_en;
    logic             n_digit;

    assign i_in.ready = (r_state == T_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    drfe_bcd_conv #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_value (i_in.value),
        .o_stat  (w_stat),
        .o_bcd   (w_bcd)
    );

    // In the emit state, load a byte whenever the output register is empty or being drained
    assign w_load    = (r_state == T_EMIT) && (!r_out_valid || o_out.ready);
    assign w_dig_end = POS_DIGIT + POS_W'(r_nd);
    assign w_off     = 3'(r_pos - w_dig_end);
    assign w_count   = r_nd + ND_W'(1);

    // Select the byte at the current frame position
    always_comb begin
        n_byte   = CH_ZERO;
        n_last   = 1'b0;
        n_crc_en = 1'b0;
        n_digit  = 1'b0;
        if (r_pos < POS_CNT_HI) begin
            n_byte = (r_pos == POS_W'(1)) ? CH_B : CH_ZERO;
        end else if (r_pos == POS_CNT_HI) begin
            n_byte = (w_count >= ND_W'(10)) ? (CH_ZERO + 8'd1) : CH_ZERO;
        end else if (r_pos == POS_CNT_LO) begin
            n_byte = (w_count >= ND_W'(10))
                   ? (CH_ZERO + {4'h0, w_count - ND_W'(10)})
                   : (CH_ZERO + {4'h0, w_count});
        end else if (r_pos == POS_SIGN) begin
            n_byte   = r_neg ? CH_NEG : CH_POS;
            n_crc_en = 1'b1;
        end else if (r_pos < w_dig_end) begin
            n_byte   = CH_ZERO + {4'h0, r_bcd[BCD_W-1 -: 4]};
            n_crc_en = 1'b1;
            n_digit  = 1'b1;
        end else begin
            case (w_off)
                3'd0:    n_byte = hex_char(r_crc[15:12]);
                3'd1:    n_byte = hex_char(r_crc[11:8]);
                3'd2:    n_byte = hex_char(r_crc[7:4]);
                3'd3:    n_byte = hex_char(r_crc[3:0]);
                OFF_CR:  n_byte = CH_CR;
                OFF_LF: begin
                    n_byte = CH_LF;
                    n_last = 1'b1;
                end
                default: n_byte = CH_ZERO;
            endcase
        end
    end

    // Advance the frame sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            case (r_state)
                T_IDLE:  if (w_accept) begin
                    r_state <= T_WAIT;
                end
                T_WAIT:  if (w_stat.done) begin
                    r_state <= T_EMIT;
                end
                T_EMIT:  if (w_load && n_last) begin
                    r_state <= T_IDLE;
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    // Capture the digits and walk through the frame
    always_ff @(posedge i_clk) begin
        if ((r_state == T_WAIT) && w_stat.done) begin
            r_bcd <= w_bcd;
            r_nd  <= w_stat.nd;
            r_neg <= w_stat.neg;
            r_pos <= '0;
            r_crc <= CRC_INIT;
        end else if (w_load) begin
            r_pos <= r_pos + POS_W'(1);
            if (n_crc_en) begin
                r_crc <= crc_byte(r_crc, n_byte);
            end
            if (n_digit) begin
                r_bcd <= r_bcd << 4;
            end
        end
    end

    // Hold the output transaction until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_byte <= n_byte;
            r_out_last <= n_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.frame_byte = r_out_byte;
    assign o_out.last_byte  = r_out_last;

    // Checks
    a_last_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last_byte) |-> (o_out.frame_byte == CH_LF))
        else $error("last byte flag on a byte other than line feed");

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> (r_state == T_WAIT))
        else $error("converter finished while sequencer not waiting");

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_EMIT) |-> (r_pos <= POS_MAX))
        else $error("frame position ran past the end of the frame");

    a_lf_ends_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && n_last) |=> (r_state == T_IDLE))
        else $error("sequencer did not return to idle after line feed");

endmodule

[sv/drfe_bcd_conv.sv]
module drfe_bcd_conv #(
    parameter int  MAX_DIGITS = 10,
    localparam int BCD_DIGITS = drfe_pkg::bcd_digits(MAX_DIGITS),
    localparam int BCD_W      = 4 * BCD_DIGITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  drfe_pkg::t_value     i_value,
    output drfe_pkg::t_conv_stat o_stat,
    output logic [BCD_W-1:0]     o_bcd
);
    import drfe_pkg::*;

    localparam logic [63:0]      MAG_MAX   = pow10(MAX_DIGITS) - 64'd1;
    localparam logic [POS_W-1:0] CONV_LAST = POS_W'(MAG_W - 1);

    typedef enum logic [4:0] {
        C_IDLE  = 5'b00001,
        C_MAG   = 5'b00010,
        C_CLAMP = 5'b00100,
        C_CONV  = 5'b01000,
        C_STRIP = 5'b10000
    } t_cstate;

    t_cstate              r_state, n_state;
    logic [MAG_W-1:0]     r_raw;
    logic [MAG_W-1:0]     r_mag;
    logic [MAG_W-1:0]     n_mag;
    logic                 r_neg;
    logic [BCD_W-1:0]     r_bcd;
    logic [BCD_W-1:0]     n_adj;
    logic [POS_W-1:0]     r_cnt;
    logic [ND_W-1:0]      r_nd;
    logic                 w_lead_zero;

    // Magnitude of the input, most negative value pinned one step in
    always_comb begin
        n_mag = r_raw[MAG_W-1] ? (~r_raw + MAG_W'(1)) : r_raw;
        if (n_mag[MAG_W-1]) begin
            n_mag = {1'b0, {(MAG_W-1){1'b1}}};
        end
    end

    // Add three to every BCD digit of five or more before the shift
    always_comb begin
        n_adj = r_bcd;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                n_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end
        end
    end

    assign w_lead_zero = (r_nd != '0) && (r_bcd[BCD_W-1 -: 4] == 4'd0);

    // Advance the conversion sequence
    always_comb begin
        n_state = r_state;
        case (r_state)
            C_IDLE:  if (i_start) begin
                n_state = C_MAG;
            end
            C_MAG:   n_state = C_CLAMP;
            C_CLAMP: n_state = C_CONV;
            C_CONV:  if (r_cnt == CONV_LAST) begin
                n_state = C_STRIP;
            end
            C_STRIP: if (!w_lead_zero) begin
                n_state = C_IDLE;
            end
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath: load, form the magnitude, clamp, shift one bit per cycle, drop leading zeros
    always_ff @(posedge i_clk) begin
        case (r_state)
            C_IDLE: begin
                r_raw <= i_value;
            end
            C_MAG: begin
                r_neg <= r_raw[MAG_W-1];
                r_mag <= n_mag;
            end
            C_CLAMP: begin
                if ({{(64-MAG_W){1'b0}}, r_mag} > MAG_MAX) begin
                    r_mag <= MAG_MAX[MAG_W-1:0];
                end
                r_bcd <= '0;
                r_cnt <= '0;
            end
            C_CONV: begin
                if (BCD_W > 1) begin
                    r_bcd <= {n_adj[BCD_W-2:0], r_mag[MAG_W-1]};
                end
                r_mag <= {r_mag[MAG_W-2:0], 1'b0};
                r_cnt <= r_cnt + POS_W'(1);
                r_nd  <= ND_W'(BCD_DIGITS);
            end
            C_STRIP: begin
                if (w_lead_zero) begin
                    r_bcd <= r_bcd << 4;
                    r_nd  <= r_nd - ND_W'(1);
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_stat.done = (r_state == C_STRIP) && !w_lead_zero;
    assign o_stat.neg  = r_neg;
    assign o_stat.nd   = r_nd;
    assign o_bcd       = r_bcd;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import drfe_pkg::*;

    localparam int FRAME_DIGITS   = 10;
    localparam int RANDOM_VALUES  = 400;
    localparam int TAIL_VALUES    = 60;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int NUM_DIRECTED   = 22;

    // One byte of the reply frame as it should leave the block
    typedef struct {
        t_byte frame_byte;
        logic  last_byte;
    } t_frame_char;

    typedef t_frame_char t_frame_q[$];

    // Directed value, with the frame head spelled out where it is obvious
    typedef struct {
        logic [31:0] value;
        string       head;
    } t_directed_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    drfe_in_if  in_bus ();
    drfe_out_if out_bus ();

    decimal_reply_frame_encoder_unit #(
        .MAX_DIGITS(FRAME_DIGITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    t_frame_q    reply_bytes_q;
    string       frame_head_q[$];
    int          error_count    = 0;
    int          stalled_cycles = 0;
    int          out_stall_left = 0;
    logic        tail_phase     = 1'b0;

    t_directed_row directed_rows [NUM_DIRECTED] = '{
        '{32'd0,          "0B00011"},
        '{32'd1,          "0B000211"},
        '{32'hFFFFFFFF,   "0B000221"},
        '{32'd9,          "0B000219"},
        '{32'd10,         "0B0003110"},
        '{32'hFFFFFFF6,   "0B0003210"},
        '{32'h7FFFFFFF,   "0B001112147483647"},
        '{32'h80000001,   "0B001122147483647"},
        '{32'h80000000,   "0B001122147483647"},
        '{32'd1000000000, "0B001111000000000"},
        '{-32'sd999999999, "0B00102999999999"},
        '{32'd99,         ""},
        '{-32'sd100,      ""},
        '{32'd123456789,  ""},
        '{-32'sd12345,    ""},
        '{32'd65535,      ""},
        '{32'h55555555,   ""},
        '{32'hAAAAAAAA,   ""},
        '{32'h7FFFFFFE,   ""},
        '{32'h80000002,   ""},
        '{32'd4096,       ""},
        '{-32'sd1000000000, ""}
    };

    // Clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Build the full reply frame for one value
    function automatic t_frame_q build_reply(t_value v);
        t_frame_q        frame;
        logic [31:0]     raw;
        logic            neg;
        longint unsigned mag;
        longint unsigned ceiling;
        t_byte           body[$];
        logic [15:0]     crc;
        logic [3:0]      nib;
        int unsigned     count;

        raw = v;
        neg = raw[31];
        mag = neg ? (64'h1_0000_0000 - {32'h0, raw}) : {32'h0, raw};
        // clamp the most negative value, then to the digit limit
        if (mag > 64'd2147483647) begin
            mag = 64'd2147483647;
        end
        ceiling = 1;
        for (int k = 0; k < FRAME_DIGITS && k < 19; k++) begin
            ceiling = ceiling * 10;
        end
        if (mag > ceiling - 1) begin
            mag = ceiling - 1;
        end

        // sign first, then digits most significant first
        while (mag != 0) begin
            body.push_front(CH_ZERO + t_byte'(mag % 10));
            mag = mag / 10;
        end
        count = body.size() + 1;
        body.push_front(neg ? CH_NEG : CH_POS);

        frame.push_back('{CH_ZERO, 1'b0});
        frame.push_back('{CH_B, 1'b0});
        frame.push_back('{CH_ZERO, 1'b0});
        frame.push_back('{CH_ZERO, 1'b0});
        frame.push_back('{CH_ZERO + t_byte'((count / 10) % 10), 1'b0});
        frame.push_back('{CH_ZERO + t_byte'(count % 10), 1'b0});

        // reflected CRC-16 over sign and digits
        crc = CRC_INIT;
        foreach (body[i]) begin
            frame.push_back('{body[i], 1'b0});
            crc = crc ^ {8'h00, body[i]};
            for (int b = 0; b < 8; b++) begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end

        for (int s = 3; s >= 0; s--) begin
            nib = crc[s*4 +: 4];
            frame.push_back('{(nib > 4'd9) ? (CH_HEX_A + t_byte'(nib) - 8'd9)
                                           : (CH_ZERO + t_byte'(nib)), 1'b0});
        end
        frame.push_back('{CH_CR, 1'b0});
        frame.push_back('{CH_LF, 1'b1});
        return frame;
    endfunction

    // Pick a value, each kind equally likely: raw bits, spread over digit counts, small, edges, one set or cleared bit
    function automatic t_value random_value();
        longint unsigned lo;
        longint unsigned hi;
        int unsigned     nd;
        t_value          v;

        case ($urandom_range(0, 4))
            0: begin
                v = $urandom;
            end
            1: begin
                nd = $urandom_range(1, 10);
                lo = 1;
                for (int k = 1; k < nd; k++) begin
                    lo = lo * 10;
                end
                hi = lo * 10 - 1;
                if (hi > 64'd2147483647) begin
                    hi = 64'd2147483647;
                end
                v = $urandom_range(int'(hi), int'(lo));
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
            2: begin
                v = $urandom_range(0, 99);
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
            3: begin
                case ($urandom_range(0, 5))
                    0: v = 32'h00000000;
                    1: v = 32'h7FFFFFFF;
                    2: v = 32'h80000000;
                    3: v = 32'h80000001;
                    4: v = 32'hFFFFFFFF;
                    default: v = 32'h00000001;
                endcase
            end
            default: begin
                v = 32'h1 << $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1) begin
                    v = ~v;
                end
            end
        endcase
        return v;
    endfunction

    // Offer one value and hold it until the block takes it
    task automatic send_value(t_value v, string head);
        if (!tail_phase && $urandom_range(0, 3) == 0) begin
            in_bus.valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        frame_head_q.push_back(head);
        in_bus.valid = 1'b1;
        in_bus.value = v;
        do begin
            @(posedge i_clk);
        end while (!in_bus.ready);
        @(negedge i_clk);
    endtask

    // Hold off the sender until the whole backlog has drained
    task automatic drain_replies();
        in_bus.valid = 1'b0;
        while (reply_bytes_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Output backpressure in random bursts
    always @(negedge i_clk) begin
        if (out_stall_left > 0) begin
            out_bus.ready = 1'b0;
            out_stall_left--;
        end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
            out_bus.ready  = 1'b0;
            out_stall_left = $urandom_range(1, 17) - 1;
        end else begin
            out_bus.ready = 1'b1;
        end
    end

    // Predict on each input transaction, check each output transaction
    always @(posedge i_clk) begin : monitor
        t_frame_q    frame;
        string       head;
        t_frame_char want;
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready) begin
                frame = build_reply(in_bus.value);
                head  = frame_head_q.pop_front();
                for (int i = 0; i < head.len(); i++) begin
                    frame[i].frame_byte = head[i];
                end
                foreach (frame[i]) begin
                    reply_bytes_q.push_back(frame[i]);
                end
            end
            if (out_bus.valid && out_bus.ready) begin
                if (reply_bytes_q.size() == 0) begin
                    $error("unexpected output byte %h", out_bus.frame_byte);
                    error_count++;
                end else begin
                    want = reply_bytes_q.pop_front();
                    if (out_bus.frame_byte !== want.frame_byte) begin
                        $error("frame_byte mismatch: expected %h, actual %h",
                               want.frame_byte, out_bus.frame_byte);
                        error_count++;
                    end
                    if (out_bus.last_byte !== want.last_byte) begin
                        $error("last_byte mismatch: expected %b, actual %b",
                               want.last_byte, out_bus.last_byte);
                        error_count++;
                    end
                end
            end
            // watchdog on cycles with no transaction on either side
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
                stalled_cycles = 0;
            end else begin
                stalled_cycles++;
                if (stalled_cycles == WATCHDOG_LIMIT) begin
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    // Stimulus
    initial begin
        in_bus.valid  = 1'b0;
        in_bus.value  = '0;
        i_rst_n       = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed values
        foreach (directed_rows[i]) begin
            send_value(directed_rows[i].value, directed_rows[i].head);
        end
        drain_replies();

        // random values, quiet tail with no idling
        for (int n = 0; n < RANDOM_VALUES; n++) begin
            if (n == RANDOM_VALUES / 2) begin
                drain_replies();
            end
            tail_phase = (n >= RANDOM_VALUES - TAIL_VALUES);
            send_value(random_value(), "");
        end
        drain_replies();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[sim.f]
sv/drfe_pkg.sv
sv/drfe_if.sv
sv/drfe_bcd_conv.sv
sv/decimal_reply_frame_encoder_unit.sv
dv/tb_top.sv
